@@ sv/bed_pkg.sv @@
package bed_pkg;

   // Queue between the decoder and the output register.
   localparam int BED_QAW    = 2;
   localparam int BED_QDEPTH = 1 << BED_QAW;
   localparam int BED_QCW    = BED_QAW + 1;

   // Character codes that steer the decoder.
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_STOP      = 8'h63;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;

   // Control bytes produced by the lettered escapes.
   localparam logic [7:0] CTL_BEL = 8'h07;
   localparam logic [7:0] CTL_BS  = 8'h08;
   localparam logic [7:0] CTL_ESC = 8'h1B;
   localparam logic [7:0] CTL_FF  = 8'h0C;
   localparam logic [7:0] CTL_LF  = 8'h0A;
   localparam logic [7:0] CTL_CR  = 8'h0D;
   localparam logic [7:0] CTL_TAB = 8'h09;
   localparam logic [7:0] CTL_VT  = 8'h0B;

   typedef enum logic [3:0] {
      PH_NORMAL = 4'b0001,
      PH_ESCAPE = 4'b0010,
      PH_OCTAL  = 4'b0100,
      PH_STOPPED = 4'b1000
   } bed_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       stopped;
      logic       last;
   } bed_rsp_type;

   // Up to two result words handed from the decoder to the queue per item.
   typedef struct packed {
      logic [1:0]  count;
      bed_rsp_type first;
      bed_rsp_type second;
   } bed_push_type;

   function automatic logic [7:0] bed_map_escape(input logic [7:0] c);
      logic [7:0] r;
      begin
         case (c)
            8'h61:   r = CTL_BEL;   // a
            8'h62:   r = CTL_BS;    // b
            8'h65:   r = CTL_ESC;   // e
            8'h45:   r = CTL_ESC;   // E
            8'h66:   r = CTL_FF;    // f
            8'h6E:   r = CTL_LF;    // n
            8'h72:   r = CTL_CR;    // r
            8'h74:   r = CTL_TAB;   // t
            8'h76:   r = CTL_VT;    // v
            default: r = c;
         endcase
         return r;
      end
   endfunction

endpackage

@@ sv/bed_front.sv @@
module bed_front
   import bed_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   char_in,
   input  logic         end_mark,
   output bed_push_type push
);

   bed_phase_type phase_ff, phase_in;
   logic [1:0]    digits_ff, digits_in;
   logic [7:0]    value_ff, value_in;

   logic          is_octal;
   logic [7:0]    value_ext;
   logic [1:0]    digits_inc;
   bed_rsp_type   plain_rsp;

   assign is_octal   = (char_in inside {[CH_ZERO:CH_SEVEN]});
   assign value_ext  = {value_ff[4:0], char_in[2:0]};
   assign digits_inc = digits_ff + 2'd1;
   assign plain_rsp  = '{out_byte: char_in, byte_valid: 1'b1, stopped: 1'b0, last: 1'b0};

   always_comb begin
      push      = '0;
      phase_in  = phase_ff;
      digits_in = digits_ff;
      value_in  = value_ff;
      if (end_mark) begin
         push.count = 2'd1;
         push.first.last = 1'b1;
         case (phase_ff)
            PH_ESCAPE: begin
               push.first.out_byte   = CH_BACKSLASH;
               push.first.byte_valid = 1'b1;
            end
            PH_OCTAL: begin
               push.first.out_byte   = value_ff;
               push.first.byte_valid = 1'b1;
            end
            PH_STOPPED: begin
               push.first.stopped = 1'b1;
            end
            default: ;
         endcase
         phase_in  = PH_NORMAL;
         digits_in = 2'd0;
         value_in  = 8'd0;
      end else begin
         case (phase_ff)
            PH_NORMAL: begin
               if (char_in == CH_BACKSLASH) begin
                  phase_in = PH_ESCAPE;
               end else begin
                  push.count = 2'd1;
                  push.first = plain_rsp;
               end
            end
            PH_ESCAPE: begin
               if (char_in == CH_STOP) begin
                  phase_in = PH_STOPPED;
               end else if (is_octal) begin
                  phase_in  = PH_OCTAL;
                  digits_in = 2'd1;
                  value_in  = {5'd0, char_in[2:0]};
               end else begin
                  phase_in   = PH_NORMAL;
                  push.count = 2'd1;
                  push.first = plain_rsp;
                  push.first.out_byte = bed_map_escape(char_in);
               end
            end
            PH_OCTAL: begin
               if (is_octal) begin
                  if (digits_inc == 2'd3 || digits_inc == 2'd0) begin
                     push.count = 2'd1;
                     push.first = plain_rsp;
                     push.first.out_byte = value_ext;
                     phase_in  = PH_NORMAL;
                     digits_in = 2'd0;
                     value_in  = 8'd0;
                  end else begin
                     digits_in = digits_inc;
                     value_in  = value_ext;
                  end
               end else begin
                  // The byte that ends the run flushes the octal value first.
                  push.first = plain_rsp;
                  push.first.out_byte = value_ff;
                  digits_in = 2'd0;
                  value_in  = 8'd0;
                  if (char_in == CH_BACKSLASH) begin
                     push.count = 2'd1;
                     phase_in   = PH_ESCAPE;
                  end else begin
                     push.count  = 2'd2;
                     push.second = plain_rsp;
                     phase_in    = PH_NORMAL;
                  end
               end
            end
            default: ;
         endcase
      end
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NORMAL;
         digits_ff <= 2'd0;
         value_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         digits_ff <= digits_in;
         value_ff  <= value_in;
      end
   end

endmodule

@@ sv/bed_queue.sv @@
module bed_queue
   import bed_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  bed_push_type         push,
   output logic                 room_two,
   input  logic                 pop,
   output logic                 not_empty,
   output bed_rsp_type          head
);

   bed_rsp_type          mem_ff [BED_QDEPTH];
   logic [BED_QAW-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [BED_QCW-1:0]   count_ff, count_in;
   logic [BED_QAW-1:0]   wptr_next;

   assign wptr_next = wptr_ff + {{(BED_QAW-1){1'b0}}, 1'b1};
   assign not_empty = (count_ff != '0);
   assign room_two  = (count_ff <= BED_QCW'(BED_QDEPTH - 2));
   assign head      = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff + BED_QAW'(push.count);
      rptr_in  = rptr_ff + BED_QAW'(pop);
      count_in = count_ff + BED_QCW'(push.count) - BED_QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ sv/bed_out.sv @@
module bed_out
   import bed_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        avail,
   input  bed_rsp_type data,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output bed_rsp_type rsp
);

   logic        valid_ff, valid_in;
   bed_rsp_type data_ff;

   assign pop       = avail && (!valid_ff || !rsp_stall);
   assign valid_in  = pop || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data;
      end
   end

endmodule

@@ sv/backslash_escape_decoder_core.sv @@
// Backslash escape decoder core.
//
// Input channel (req_): one text byte per word on req_char_in, or an end of
// string marker when req_end_mark is high. A word is taken at a rising edge
// where req_valid is high and req_stall is low.
// Result channel (rsp_): decoded bytes with rsp_byte_valid, plus rsp_stopped
// and rsp_last flags. The receiver holds rsp_stall high to stall; the word
// shown then stays unchanged until it is taken.
// Results pass through the queue into the output register, from which
// rsp_valid shows them; a result can never be taken at the edge where
// its input word is taken.
// Throughput: one input word per cycle while req_stall is low. A byte
// that ends an octal run yields two results; the extra one waits in the
// queue. req_stall rises only when fewer than two queue places are free,
// which happens when such double results pile up or the receiver stalls.
// The output register is the limit of one result per cycle.
// Reset clears the decoder state and empties the queue and output register;
// req_stall is low once reset has been applied.
module backslash_escape_decoder_core
   import bed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_mark,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_stopped,
   output logic       rsp_last
);

   bed_push_type push;
   bed_rsp_type  head;
   bed_rsp_type  rsp;
   logic         room_two;
   logic         not_empty;
   logic         pop;
   logic         accept;

   // The front end only takes a word when the queue can hold the two
   // results that the worst case produces, so it never has to hold back a
   // decoded word itself.
   assign req_stall = !room_two;
   assign accept    = req_valid && room_two;

   // Front: keeps the escape phase, octal digit count and octal value, and
   // classifies each word into zero, one or two result words.
   bed_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .char_in  (req_char_in),
      .end_mark (req_end_mark),
      .push     (push)
   );

   // Short queue that decouples the decoder from the result channel.
   bed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_two  (room_two),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   // Back: registered result port, refilled from the queue whenever the
   // current word is taken or the register is empty.
   bed_out u_out (
      .clock     (clock),
      .reset     (reset),
      .avail     (not_empty),
      .data      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_out_byte   = rsp.out_byte;
   assign rsp_byte_valid = rsp.byte_valid;
   assign rsp_stopped    = rsp.stopped;
   assign rsp_last       = rsp.last;

endmodule

@@ sv/bed_checker.sv @@
module bed_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_stopped,
   input logic       rsp_last
);

   // The result register is empty straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The queue is empty after reset, so input is taken at once.
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled after reset");

   // A stalled result word holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_valid) && $stable(rsp_stopped) && $stable(rsp_last))
      else $error("stalled result changed");

   // Only the closing word of a string may come without a byte.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last)
      else $error("byteless result that is not last");

   // A stopped string closes with a byteless last word.
   a_stop_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stopped |-> rsp_last && !rsp_byte_valid)
      else $error("stopped flag on a non-closing word");

endmodule

bind backslash_escape_decoder_core bed_checker u_bed_checker (.*);

@@ tb/tb.sv @@
module tb;

   import bed_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Roughly how many random words follow the directed opening.
   localparam int RANDOM_WORDS = 650;
   // Cycles without any word accepted on either channel before the run is
   // declared hung. Real gaps and stalls are far shorter.
   localparam int IDLE_LIMIT   = 4000;
   // Cycles allowed for late results once nothing is expected any more.
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [7:0] char_in;
      logic       end_mark;
   } text_word_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char_in;
   logic       req_end_mark;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_stopped;
   logic       rsp_last;

   backslash_escape_decoder_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .req_end_mark   (req_end_mark),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_stopped    (rsp_stopped),
      .rsp_last       (rsp_last)
   );

   // Words waiting to be offered, and decoded bytes waiting to come out.
   text_word_type pending_words[$];
   bed_rsp_type   expected_bytes[$];

   // The testbench's own copy of the decoder state.
   bed_phase_type dec_phase;
   logic [1:0]    oct_digits;
   logic [7:0]    oct_value;

   // Handshake, burst and stall bookkeeping; word_taken is shared between the clocked blocks.
   logic          word_taken;
   logic          result_taken;
   text_word_type next_word;
   int            burst_left;
   int            gap_left;
   int            stall_mode;
   int            stall_count;
   int            idle_cycles;

   // Run statistics and the error tally.
   int mismatch_count;
   int words_sent;
   int strings_closed;
   int results_checked;
   int stopped_strings;
   int octal_flushes;

   // Letters that make up the named escapes, plus the two that pass through.
   string esc_letters = "abeEfnrtv\\'";

   // Clock and the single reset pulse. Every input starts at a known value.
   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_char_in  = 8'h00;
      req_end_mark = 1'b0;
      rsp_stall    = 1'b0;
      fork
         forever #6 clock = ~clock;
         begin
            repeat (10) @(negedge clock);
            reset <= 1'b0;
         end
      join_none
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      begin
         $display("%0t tb: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
         mismatch_count++;
      end
   endtask

   task automatic add_word(input logic [7:0] c, input logic fin);
      text_word_type w;
      begin
         w.char_in  = c;
         w.end_mark = fin;
         pending_words.push_back(w);
      end
   endtask

   task automatic add_text(input string s);
      begin
         for (int i = 0; i < s.len(); i++) add_word(s[i], 1'b0);
      end
   endtask

   // One random string: a mix of plain bytes, lettered escapes, escapes of
   // arbitrary bytes, octal runs of one to three digits, the stop escape and
   // stray backslashes, closed by an end marker with a random (ignored) byte.
   task automatic add_random_string();
      int tokens;
      int kind;
      int digits;
      begin
         tokens = $urandom_range(0, 10);
         repeat (tokens) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
               add_word(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 55) begin
               add_word(CH_BACKSLASH, 1'b0);
               add_word(esc_letters[$urandom_range(0, esc_letters.len() - 1)], 1'b0);
            end else if (kind < 65) begin
               add_word(CH_BACKSLASH, 1'b0);
               add_word(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 85) begin
               digits = $urandom_range(1, 3);
               add_word(CH_BACKSLASH, 1'b0);
               repeat (digits) add_word(8'($urandom_range(CH_ZERO, CH_SEVEN)), 1'b0);
               // A following decimal digit either extends the run or, for
               // 8 and 9, flushes it and is printed itself.
               if (digits < 3 && $urandom_range(0, 1) == 1)
                  add_word(8'($urandom_range(CH_ZERO, 8'h39)), 1'b0);
            end else if (kind < 90) begin
               add_word(CH_BACKSLASH, 1'b0);
               add_word(CH_STOP, 1'b0);
            end else begin
               add_word(CH_BACKSLASH, 1'b0);
            end
         end
         if ($urandom_range(0, 9) == 0) add_word(CH_BACKSLASH, 1'b0);
         add_word(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic push_result(input logic [7:0] b, input logic valid, input logic stop,
                              input logic fin);
      bed_rsp_type r;
      begin
         r.out_byte   = valid ? b : 8'h00;
         r.byte_valid = valid;
         r.stopped    = stop;
         r.last       = fin;
         expected_bytes.push_back(r);
      end
   endtask

   task automatic clear_decoder();
      begin
         dec_phase  = PH_NORMAL;
         oct_digits = 2'd0;
         oct_value  = 8'h00;
      end
   endtask

   // Plain text: a backslash opens an escape, anything else is printed.
   task automatic take_plain(input logic [7:0] c);
      begin
         if (c == CH_BACKSLASH) dec_phase = PH_ESCAPE;
         else push_result(c, 1'b1, 1'b0, 1'b0);
      end
   endtask

   function automatic logic [7:0] escape_code(input logic [7:0] c);
      begin
         case (c)
            "a":      return CTL_BEL;
            "b":      return CTL_BS;
            "e", "E": return CTL_ESC;
            "f":      return CTL_FF;
            "n":      return CTL_LF;
            "r":      return CTL_CR;
            "t":      return CTL_TAB;
            "v":      return CTL_VT;
            default:  return c;
         endcase
      end
   endfunction

   // Works out the decoded bytes that one accepted word gives rise to and
   // appends them to the expectation queue.
   task automatic decode_word(input logic [7:0] c, input logic fin);
      logic is_octal;
      begin
         is_octal = (c >= CH_ZERO) && (c <= CH_SEVEN);
         if (fin) begin
            // The end marker flushes whatever is pending and closes the string.
            case (dec_phase)
               PH_ESCAPE:  push_result(CH_BACKSLASH, 1'b1, 1'b0, 1'b1);
               PH_OCTAL:   push_result(oct_value, 1'b1, 1'b0, 1'b1);
               PH_STOPPED: push_result(8'h00, 1'b0, 1'b1, 1'b1);
               default:    push_result(8'h00, 1'b0, 1'b0, 1'b1);
            endcase
            clear_decoder();
         end else begin
            case (dec_phase)
               PH_NORMAL: take_plain(c);
               PH_ESCAPE: begin
                  if (c == CH_STOP) begin
                     dec_phase = PH_STOPPED;
                  end else if (is_octal) begin
                     dec_phase  = PH_OCTAL;
                     oct_digits = 2'd1;
                     oct_value  = c - CH_ZERO;
                  end else begin
                     dec_phase = PH_NORMAL;
                     push_result(escape_code(c), 1'b1, 1'b0, 1'b0);
                  end
               end
               PH_OCTAL: begin
                  if (is_octal) begin
                     // The value wraps modulo 256, so three digits up to 0777.
                     oct_value  = (oct_value << 3) + (c - CH_ZERO);
                     oct_digits = oct_digits + 2'd1;
                     if (oct_digits == 2'd3) begin
                        push_result(oct_value, 1'b1, 1'b0, 1'b0);
                        clear_decoder();
                     end
                  end else begin
                     // The run ends early: its byte comes first, then this word is handled as plain text.
                     push_result(oct_value, 1'b1, 1'b0, 1'b0);
                     clear_decoder();
                     take_plain(c);
                     octal_flushes++;
                  end
               end
               default: ;
            endcase
         end
      end
   endtask

   // Sender. Inputs change on the falling edge only. A word stays on the
   // bus until it has been taken; after that the next one is offered, or the
   // bus goes quiet for the gap that closes a burst. Roughly a third of the
   // bursts are followed by no gap at all, giving long unbroken stretches.
   always @(negedge clock) begin
      if (!reset && (!req_valid || word_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            next_word = pending_words.pop_front();
            req_char_in  <= next_word.char_in;
            req_end_mark <= next_word.end_mark;
            req_valid    <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               case ($urandom_range(0, 5))
                  0, 1:    gap_left = 0;
                  5:       gap_left = $urandom_range(7, 20);
                  default: gap_left = $urandom_range(1, 6);
               endcase
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end

      // Receiver. It keeps switching to a randomly chosen habit: never stalling,
      // stalling now and then, stalling in a fixed rhythm, or stalling
      // nearly all the time. The rhythm makes stalls land on every phase of
      // a double result as the offsets drift.
      stall_count++;
      if (stall_count % 48 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 9) < 3);
         2:       rsp_stall <= (stall_count % 7 < 4);
         default: rsp_stall <= ($urandom_range(0, 9) < 8);
      endcase
   end

   // Both channels are sampled on the rising edge. The predictor runs on
   // every accepted input word, and every accepted result word is compared
   // field by field with the oldest expectation. A result can never be taken
   // at the same edge as the word that caused it, so the order of the two
   // steps does not matter.
   always @(posedge clock) begin
      if (reset) begin
         word_taken  = 1'b0;
         idle_cycles = 0;
      end else begin
         word_taken   = req_valid && !req_stall;
         result_taken = rsp_valid && !rsp_stall;
         if (word_taken) begin
            decode_word(req_char_in, req_end_mark);
            words_sent++;
            if (req_end_mark) strings_closed++;
         end
         if (result_taken) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("result word with nothing expected, out_byte",
                               int'(rsp_out_byte), -1);
            end else begin
               bed_rsp_type want;
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch("out_byte", int'(rsp_out_byte), int'(want.out_byte));
               if (rsp_byte_valid !== want.byte_valid)
                  report_mismatch("byte_valid", int'(rsp_byte_valid),
                                  int'(want.byte_valid));
               if (rsp_stopped !== want.stopped)
                  report_mismatch("stopped", int'(rsp_stopped), int'(want.stopped));
               if (rsp_last !== want.last)
                  report_mismatch("last", int'(rsp_last), int'(want.last));
               if (want.stopped) stopped_strings++;
            end
            results_checked++;
         end
         // Watchdog: a long spell with no word moving on either side means
         // the block has hung.
         if (word_taken || result_taken) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int directed_words;

      mismatch_count  = 0;
      words_sent      = 0;
      strings_closed  = 0;
      results_checked = 0;
      stopped_strings = 0;
      octal_flushes   = 0;
      burst_left      = 0;
      gap_left        = 0;
      stall_mode      = 0;
      stall_count     = 0;
      word_taken      = 1'b0;
      result_taken    = 1'b0;
      clear_decoder();

      // Directed opening. First the byte extremes, a lettered escape, an
      // escaped backslash and an escaped zero byte, which must pass as zero.
      add_word(8'h00, 1'b0);
      add_word(8'hFF, 1'b0);
      add_text("\\n\\\\");
      add_word(CH_BACKSLASH, 1'b0);
      add_word(8'h00, 1'b0);
      add_word(8'h5A, 1'b1);
      // A three digit run that overflows, a run cut short by an 8 (two
      // results from one word), and a run still open at the end marker.
      add_text("\\777\\18\\2");
      add_word(8'hA5, 1'b1);
      // The stop escape with a byte after it that must vanish.
      add_text("\\cx");
      add_word(8'h00, 1'b1);
      // A lone backslash at the end, then an empty string.
      add_text("\\");
      add_word(8'hFF, 1'b1);
      add_word(8'h00, 1'b1);
      directed_words = pending_words.size();

      while (pending_words.size() < directed_words + RANDOM_WORDS) add_random_string();

      // Let everything go in, wait for every expected word to come out, and
      // then run on for the drain time, so that any stray result can show.
      @(negedge reset);
      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d words sent in %0d strings, %0d result words checked",
               words_sent, strings_closed, results_checked);
      $display("tb: %0d strings ended by a stop escape, %0d octal runs cut short",
               stopped_strings, octal_flushes);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
